[rtl/core/knn_pkg.sv]
// Package for the k-nearest-neighbor classifier: payload structs, sizes and codes.
// Used by knn_classifier_top; has no dependencies of its own.
`timescale 1ns / 1ps

package knn_pkg;

   // Storage sizes.
   localparam int MAX_ROWS     = 1024;
   localparam int MAX_FEATURES = 16;
   localparam int MAX_K        = 16;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int FEAT_W = $clog2(MAX_FEATURES);
   localparam int KIDX_W = $clog2(MAX_K);
   localparam int ADDR_W = ROW_W + FEAT_W;
   localparam int DIST_W = 37;
   localparam int SQ_W   = 32;
   localparam int LBL_W  = 16;
   localparam int VAL_W  = 16;

   // Configuration register widths.
   localparam int K_CFG_W    = 5;
   localparam int NF_CFG_W   = 5;
   localparam int ROWS_CFG_W = 11;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_NEIGHBOR_COUNT  = 2'd0,
      REG_FEATURES_IN_USE = 2'd1,
      REG_ROWS_IN_USE     = 2'd2,
      REG_UNUSED          = 2'd3
   } reg_index_type;

   // Transaction kinds.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [ROW_W-1:0]        row_index;
      logic [FEAT_W-1:0]       feature_index;
      logic signed [VAL_W-1:0] feature_value;
      logic signed [LBL_W-1:0] row_label;
   } req_payload_type;

   typedef struct packed {
      logic signed [LBL_W-1:0] predicted_label;
      logic                    status;
   } rsp_payload_type;

endpackage

[rtl/core/knn_ram.sv]
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; used by knn_classifier_top for the training feature and label stores.
`timescale 1ns / 1ps

module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/knn_classifier_top.sv]
// Top level of the k-nearest-neighbor classifier.
// Depends on knn_pkg and instantiates knn_ram for the training stores.
`timescale 1ns / 1ps

// A load transaction writes one training feature and its row label. A query
// transaction writes one query feature; the one that writes the last query
// feature also starts a walk of all rows through a single distance unit fed by
// the one read port of the feature memory, one feature per cycle. The block is
// then busy and takes no transaction until the result is in the output register.
// The busy span is the walk, the drain of the distance pipeline and the
// insertion of the last row, a vote step for each kept neighbor, and the move of
// the result into the output register. With no rows in use it skips to that
// move and reports an empty status. The result is held in an output register
// until it is taken. A result that finishes while the previous one still
// waits keeps the block busy until the previous one is taken.
module knn_classifier_top
   import knn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_VOTE,
      S_DONE
   } state_type;

   // Configuration registers.
   logic [K_CFG_W-1:0]    k_cfg_ff;
   logic [NF_CFG_W-1:0]   nf_cfg_ff;
   logic [ROWS_CFG_W-1:0] rows_cfg_ff;
   reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_cfg_ff    <= K_CFG_W'(1);
         nf_cfg_ff   <= NF_CFG_W'(1);
         rows_cfg_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (csr_index)
            REG_NEIGHBOR_COUNT:  k_cfg_ff    <= pwdata[K_CFG_W-1:0];
            REG_FEATURES_IN_USE: nf_cfg_ff   <= pwdata[NF_CFG_W-1:0];
            REG_ROWS_IN_USE:     rows_cfg_ff <= pwdata[ROWS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      prdata = '0;
      unique case (csr_index)
         REG_NEIGHBOR_COUNT:  prdata = 32'(k_cfg_ff);
         REG_FEATURES_IN_USE: prdata = 32'(nf_cfg_ff);
         REG_ROWS_IN_USE:     prdata = 32'(rows_cfg_ff);
         default:             prdata = '0;
      endcase
   end

   // Effective (saturated) configuration values.
   logic [K_CFG_W-1:0]    k_eff;
   logic [NF_CFG_W-1:0]   nf_eff;
   logic [ROWS_CFG_W-1:0] rows_eff;

   always_comb begin
      if (k_cfg_ff == '0)                       k_eff = K_CFG_W'(1);
      else if (k_cfg_ff > K_CFG_W'(MAX_K))      k_eff = K_CFG_W'(MAX_K);
      else                                      k_eff = k_cfg_ff;
      if (nf_cfg_ff == '0)                      nf_eff = NF_CFG_W'(1);
      else if (nf_cfg_ff > NF_CFG_W'(MAX_FEATURES)) nf_eff = NF_CFG_W'(MAX_FEATURES);
      else                                      nf_eff = nf_cfg_ff;
      if (rows_cfg_ff > ROWS_CFG_W'(MAX_ROWS))  rows_eff = ROWS_CFG_W'(MAX_ROWS);
      else                                      rows_eff = rows_cfg_ff;
   end

   // Control and pipeline registers.
   state_type            state_ff, state_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [FEAT_W-1:0]    feat_ff, feat_in;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_first_ff, s1_last_ff;
   logic [FEAT_W-1:0]    s1_feat_ff;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 s2_first_ff, s2_last_ff;
   logic [SQ_W-1:0]      s2_sq_ff;
   logic signed [LBL_W-1:0] s2_label_ff;
   logic [DIST_W-1:0]    acc_ff, acc_in;
   logic                 done_valid_ff, done_valid_in;
   logic [DIST_W-1:0]    done_dist_ff, done_dist_in;
   logic signed [LBL_W-1:0] done_label_ff, done_label_in;
   logic [KIDX_W:0]      filled_ff, filled_in;
   logic [DIST_W-1:0]    best_dist_ff [MAX_K];
   logic [DIST_W-1:0]    best_dist_in [MAX_K];
   logic signed [LBL_W-1:0] best_label_ff [MAX_K];
   logic signed [LBL_W-1:0] best_label_in [MAX_K];
   logic [KIDX_W-1:0]    vote_idx_ff, vote_idx_in;
   logic [KIDX_W:0]      vote_count_ff, vote_count_in;
   logic signed [LBL_W-1:0] winner_ff, winner_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;
   rsp_payload_type      result_ff, result_in;
   logic signed [VAL_W-1:0] qbuf_ff [MAX_FEATURES];

   // Training memories.
   logic                 load_fire;
   logic                 query_fire;
   logic                 trigger;
   logic [VAL_W-1:0]     feat_rd;
   logic [LBL_W-1:0]     label_rd;

   assign req_ready  = (state_ff == S_IDLE);
   assign load_fire  = req_valid && req_ready && (req_payload.func == FUNC_LOAD);
   assign query_fire = req_valid && req_ready && (req_payload.func == FUNC_QUERY);
   assign trigger    = query_fire &&
                       ({1'b0, req_payload.feature_index} == nf_eff - NF_CFG_W'(1));

   knn_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS * MAX_FEATURES)) u_feat_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr ({req_payload.row_index, req_payload.feature_index}),
      .wr_data (req_payload.feature_value),
      .rd_addr ({row_ff, feat_ff}),
      .rd_data (feat_rd)
   );

   knn_ram #(.WIDTH(LBL_W), .DEPTH(MAX_ROWS)) u_label_ram (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_payload.row_index),
      .wr_data (req_payload.row_label),
      .rd_addr (row_ff),
      .rd_data (label_rd)
   );

   // Distance unit: difference and square of one feature.
   logic signed [VAL_W:0]     diff;
   logic signed [2*VAL_W+1:0] prod;
   logic [SQ_W-1:0]           sq;
   logic [DIST_W-1:0]         sum;

   assign diff = {qbuf_ff[s1_feat_ff][VAL_W-1], qbuf_ff[s1_feat_ff]}
               - {feat_rd[VAL_W-1], feat_rd};
   assign prod = diff * diff;
   assign sq   = prod[SQ_W-1:0];
   assign sum  = (s2_first_ff ? '0 : acc_ff) + DIST_W'(s2_sq_ff);

   // Ordered insertion of a finished row into the best list.
   logic [MAX_K-1:0] ahead;
   logic             insert_ok;
   logic [KIDX_W-1:0] k_last;

   assign k_last = KIDX_W'(k_eff - K_CFG_W'(1));

   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         ahead[j] = ((KIDX_W+1)'(j) < filled_ff) &&
                    ((best_dist_ff[j] < done_dist_ff) ||
                     ((best_dist_ff[j] == done_dist_ff) &&
                      (best_label_ff[j] <= done_label_ff)));
      end
      insert_ok = (filled_ff < (KIDX_W+1)'(k_eff)) || !ahead[k_last];
   end

   // Vote: count the label at vote_idx among the filled entries.
   logic [MAX_K-1:0] match;
   logic [KIDX_W:0]  count;

   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         match[j] = ((KIDX_W+1)'(j) < filled_ff) &&
                    (best_label_ff[j] == best_label_ff[vote_idx_ff]);
      end
      count = (KIDX_W+1)'($countones(match));
   end

   // Next-state logic.
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      feat_in        = feat_ff;
      s1_valid_in    = 1'b0;
      s2_valid_in    = s1_valid_ff;
      acc_in         = acc_ff;
      done_valid_in  = 1'b0;
      done_dist_in   = done_dist_ff;
      done_label_in  = done_label_ff;
      filled_in      = filled_ff;
      best_dist_in   = best_dist_ff;
      best_label_in  = best_label_ff;
      vote_idx_in    = vote_idx_ff;
      vote_count_in  = vote_count_ff;
      winner_in      = winner_ff;
      result_in      = result_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;

      // Accumulate one squared difference; the row's last feature closes it.
      if (s2_valid_ff) begin
         acc_in = sum;
         if (s2_last_ff) begin
            done_valid_in = 1'b1;
            done_dist_in  = sum;
            done_label_in = s2_label_ff;
         end
      end

      // Insert a finished row, shifting later entries down by one.
      if (done_valid_ff && insert_ok) begin
         for (int j = 0; j < MAX_K; j++) begin
            if (!ahead[j] && ((KIDX_W+1)'(j) < (KIDX_W+1)'(k_eff))) begin
               if (j == 0 || ahead[(j == 0) ? 0 : j-1]) begin
                  best_dist_in[j]  = done_dist_ff;
                  best_label_in[j] = done_label_ff;
               end else begin
                  best_dist_in[j]  = best_dist_ff[(j == 0) ? 0 : j-1];
                  best_label_in[j] = best_label_ff[(j == 0) ? 0 : j-1];
               end
            end
         end
         if (filled_ff < (KIDX_W+1)'(k_eff)) begin
            filled_in = filled_ff + (KIDX_W+1)'(1);
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (trigger) begin
               filled_in = '0;
               row_in    = '0;
               feat_in   = '0;
               if (rows_eff == '0) begin
                  result_in.predicted_label = '0;
                  result_in.status          = STATUS_EMPTY;
                  state_in                  = S_DONE;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // Issue one feature read per cycle.
            s1_valid_in = 1'b1;
            if ({1'b0, feat_ff} == nf_eff - NF_CFG_W'(1)) begin
               feat_in = '0;
               if ({1'b0, row_ff} == rows_eff - ROWS_CFG_W'(1)) begin
                  state_in = S_DRAIN;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               feat_in = feat_ff + FEAT_W'(1);
            end
         end
         S_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff && !done_valid_ff) begin
               vote_idx_in   = '0;
               vote_count_in = '0;
               winner_in     = '0;
               state_in      = S_VOTE;
            end
         end
         S_VOTE: begin
            if ((count > vote_count_ff) ||
                ((count == vote_count_ff) && (best_label_ff[vote_idx_ff] < winner_ff))) begin
               vote_count_in = count;
               winner_in     = best_label_ff[vote_idx_ff];
            end
            if ((KIDX_W+1)'(vote_idx_ff) == filled_ff - (KIDX_W+1)'(1)) begin
               result_in.predicted_label = winner_in;
               result_in.status          = STATUS_OK;
               state_in                  = S_DONE;
            end else begin
               vote_idx_in = vote_idx_ff + KIDX_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         done_valid_ff  <= 1'b0;
         filled_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_payload_ff <= '0;
      end else begin
         state_ff       <= state_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         done_valid_ff  <= done_valid_in;
         filled_ff      <= filled_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      feat_ff        <= feat_in;
      s1_feat_ff     <= feat_ff;
      s1_first_ff    <= (feat_ff == '0);
      s1_last_ff     <= ({1'b0, feat_ff} == nf_eff - NF_CFG_W'(1));
      s2_sq_ff       <= sq;
      s2_first_ff    <= s1_first_ff;
      s2_last_ff     <= s1_last_ff;
      s2_label_ff    <= label_rd;
      acc_ff         <= acc_in;
      done_dist_ff   <= done_dist_in;
      done_label_ff  <= done_label_in;
      best_dist_ff   <= best_dist_in;
      best_label_ff  <= best_label_in;
      vote_idx_ff    <= vote_idx_in;
      vote_count_ff  <= vote_count_in;
      winner_ff      <= winner_in;
      result_ff      <= result_in;
      if (query_fire) begin
         qbuf_ff[req_payload.feature_index] <= req_payload.feature_value;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[tb/tb.sv]
// Self-checking testbench for knn_classifier_top: loads training rows, runs queries,
// and compares each classification against an internal prediction. Depends on knn_pkg.
`timescale 1ns / 1ps

import knn_pkg::*;

// Scoreboard: mirrors the classifier state and keeps the queue of predicted results.
class knn_scoreboard;
   logic signed [VAL_W-1:0] feat_mem [MAX_ROWS*MAX_FEATURES];
   logic signed [LBL_W-1:0] label_mem [MAX_ROWS];
   logic signed [VAL_W-1:0] query_vec [MAX_FEATURES];
   logic [K_CFG_W-1:0]      k_reg;
   logic [NF_CFG_W-1:0]     nf_reg;
   logic [ROWS_CFG_W-1:0]   rows_reg;
   rsp_payload_type         pending_labels [$];
   int                      fail_count;

   function new();
      k_reg = K_CFG_W'(1);
      nf_reg = NF_CFG_W'(1);
      rows_reg = '0;
      fail_count = 0;
   endfunction

   function void write_reg(reg_index_type idx, logic [31:0] value);
      case (idx)
         REG_NEIGHBOR_COUNT:  k_reg = value[K_CFG_W-1:0];
         REG_FEATURES_IN_USE: nf_reg = value[NF_CFG_W-1:0];
         REG_ROWS_IN_USE:     rows_reg = value[ROWS_CFG_W-1:0];
         default: ;
      endcase
   endfunction

   function int eff_features();
      if (nf_reg == 0) return 1;
      return (nf_reg > MAX_FEATURES) ? MAX_FEATURES : int'(nf_reg);
   endfunction

   // Note one accepted transaction and predict its classification, if any.
   function void note_request(req_payload_type t);
      longint near_dist [MAX_K];
      int     lbl [MAX_K];
      int     filled, k, nf, rows, pos, cnt, best_cnt, winner;
      longint sum, d;
      rsp_payload_type r;
      if (t.func == FUNC_LOAD) begin
         feat_mem[t.row_index*MAX_FEATURES + t.feature_index] = t.feature_value;
         label_mem[t.row_index] = t.row_label;
         return;
      end
      query_vec[t.feature_index] = t.feature_value;
      nf = eff_features();
      if (t.feature_index != nf - 1) return;
      rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
      if (rows == 0) begin
         r.predicted_label = '0;
         r.status = STATUS_EMPTY;
         pending_labels = {pending_labels, r};
         return;
      end
      k = (k_reg == 0) ? 1 : ((k_reg > MAX_K) ? MAX_K : int'(k_reg));
      filled = 0;
      for (int row = 0; row < rows; row++) begin
         sum = 0;
         for (int f = 0; f < nf; f++) begin
            d = longint'(query_vec[f]) - longint'(feat_mem[row*MAX_FEATURES + f]);
            sum += d * d;
         end
         // Sorted insert: by distance, then by smaller label.
         pos = 0;
         while (pos < filled && (near_dist[pos] < sum ||
                (near_dist[pos] == sum && lbl[pos] <= int'(label_mem[row]))))
            pos++;
         if (pos < k) begin
            for (int i = (filled < k) ? filled : k - 1; i > pos; i--) begin
               near_dist[i] = near_dist[i-1];
               lbl[i] = lbl[i-1];
            end
            near_dist[pos] = sum;
            lbl[pos] = label_mem[row];
            if (filled < k) filled++;
         end
      end
      // Majority vote; ties go to the smaller label.
      best_cnt = 0;
      winner = 0;
      for (int i = 0; i < filled; i++) begin
         cnt = 0;
         for (int j = 0; j < filled; j++)
            if (lbl[j] == lbl[i]) cnt++;
         if (cnt > best_cnt || (cnt == best_cnt && lbl[i] < winner)) begin
            best_cnt = cnt;
            winner = lbl[i];
         end
      end
      r.predicted_label = winner[LBL_W-1:0];
      r.status = STATUS_OK;
      pending_labels = {pending_labels, r};
   endfunction

   // Compare one result against the oldest prediction.
   function void check_result(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_labels.size() == 0) begin
         $error("unexpected result label=%0d status=%0d", got.predicted_label, got.status);
         fail_count++;
         return;
      end
      want = pending_labels.pop_front();
      if (got.predicted_label !== want.predicted_label) begin
         $error("predicted_label expected %0d actual %0d",
                want.predicted_label, got.predicted_label);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, got.status);
         fail_count++;
      end
   endfunction
endclass

module tb;
   logic            clock = 0;
   logic            reset = 1;
   logic            req_valid = 0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 0;
   rsp_payload_type rsp_payload;
   logic            psel = 0;
   logic            penable = 0;
   logic            pwrite = 0;
   logic [3:0]      paddr = '0;
   logic [31:0]     pwdata = '0;
   logic [31:0]     prdata;
   logic            pready;

   knn_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_rsp = 0;
   int  quiet_cycles = 0;

   localparam int WATCHDOG_LIMIT = 200000;

   knn_classifier_top i_dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Receiver: random stalls, or a long hold-off while pressure is applied.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Check results and run the no-progress watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Offer one transaction, wait for acceptance, then note it in the scoreboard.
   // Valid stays high after acceptance; the next idle gap, drain or register write drops it.
   task automatic send_item(req_payload_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_payload <= t;
      do @(posedge clock); while (!req_ready);
      board.note_request(t);
   endtask

   task automatic write_csr(reg_index_type idx, logic [31:0] value);
      req_valid <= 0;
      psel <= 1;
      pwrite <= 1;
      paddr <= 4'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      board.write_reg(idx, value);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      @(posedge clock);
   endtask

   // Drain: wait for all predictions to be consumed, then a short settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending_labels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic load_feature(int row, int fi, int value, int label);
      req_payload_type t;
      t.func = FUNC_LOAD;
      t.row_index = ROW_W'(row);
      t.feature_index = FEAT_W'(fi);
      t.feature_value = VAL_W'(value);
      t.row_label = LBL_W'(label);
      send_item(t);
   endtask

   task automatic query_feature(int fi, int value);
      req_payload_type t;
      t.func = FUNC_QUERY;
      t.row_index = ROW_W'($urandom);
      t.feature_index = FEAT_W'(fi);
      t.feature_value = VAL_W'(value);
      t.row_label = LBL_W'($urandom);
      send_item(t);
   endtask

   // Load rows [0, n) fully with features; labels mostly from a small set to force ties.
   task automatic load_rows(int n, int nf);
      int lab;
      for (int r = 0; r < n; r++) begin
         lab = ($urandom_range(3) == 0) ? int'($urandom) : $urandom_range(3) - 1;
         for (int f = 0; f < nf; f++)
            load_feature(r, f, ($urandom_range(3) == 0) ? int'($urandom)
                                 : $urandom_range(600) - 300, lab);
      end
   endtask

   // Full query: all features, the last one triggers the walk.
   task automatic run_query(int nf);
      for (int f = 0; f < nf; f++)
         query_feature(f, ($urandom_range(3) == 0) ? int'($urandom)
                             : $urandom_range(600) - 300);
   endtask

   task automatic random_phase(int idle, int stall, int nf, int k, int rows, int queries);
      drain();
      send_idle_pct = idle;
      recv_stall_pct = stall;
      write_csr(REG_FEATURES_IN_USE, nf);
      write_csr(REG_NEIGHBOR_COUNT, k);
      load_rows(rows, nf);
      write_csr(REG_ROWS_IN_USE, rows);
      for (int q = 0; q < queries; q++) begin
         // Occasional extra query write; it has no result unless only one feature is in use.
         if ($urandom_range(5) == 0)
            query_feature($urandom_range(nf > 1 ? nf - 2 : 0), $urandom);
         run_query(nf);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: empty training set, then extremes of values and labels.
      write_csr(REG_ROWS_IN_USE, 0);
      query_feature(0, 16'sh7fff);
      drain();
      write_csr(REG_UNUSED, 32'h5);
      write_csr(REG_FEATURES_IN_USE, 2);
      write_csr(REG_NEIGHBOR_COUNT, 3);
      load_feature(0, 0, -32768, -32768);
      load_feature(0, 1, 32767, -32768);
      load_feature(1, 0, 32767, 32767);
      load_feature(1, 1, -32768, 32767);
      load_feature(2, 0, 0, 5);
      load_feature(2, 1, 0, 5);
      load_feature(1023, 15, 16'sh1234, 7);
      write_csr(REG_ROWS_IN_USE, 3);
      query_feature(1, 32767);
      query_feature(0, -32768);
      query_feature(1, 32767);
      query_feature(15, 0);
      drain();
      // Saturated registers: k of 31 clamps to its maximum and features of 0 to one.
      write_csr(REG_NEIGHBOR_COUNT, 31);
      write_csr(REG_FEATURES_IN_USE, 0);
      query_feature(0, 0);
      drain();
      write_csr(REG_FEATURES_IN_USE, 2);
      write_csr(REG_ROWS_IN_USE, 0);
      query_feature(1, 1);
      drain();

      // Random phases across idling patterns and settings.
      random_phase(0, 0, 3, 5, 12, 8);
      random_phase(83, 0, 1, 1, 20, 20);
      random_phase(0, 83, 16, 16, 6, 4);
      random_phase(23, 23, 4, 31, 14, 12);
      random_phase(0, 0, 5, 2, 4, 10);
      random_phase(23, 23, 2, 0, 30, 20);

      // Pressure: receiver holds off while queries keep coming.
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(REG_FEATURES_IN_USE, 1);
      write_csr(REG_ROWS_IN_USE, 2);
      hold_rsp <= 1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp <= 0;
         end
         for (int q = 0; q < 6; q++) run_query(1);
      join

      random_phase(0, 0, 1, 3, 10, 10);

      drain();
      repeat (100) @(posedge clock);
      if (board.fail_count == 0 && board.pending_labels.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[sim.f]
rtl/core/knn_pkg.sv
rtl/core/knn_ram.sv
rtl/core/knn_classifier_top.sv
tb/tb.sv
